### src/uer_pkg.sv
package uer_pkg;

    // Echo counter width
    localparam int CountWidth = 16;
    // Running product of count and scale
    localparam int ProdWidth = CountWidth + 16;
    // Width used for count against limit compares
    localparam int CmpWidth = (CountWidth > 16) ? CountWidth : 16;

    localparam int DistWidth = 10;
    localparam int DigitWidth = 4;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 16;

    localparam logic [DistWidth-1:0] DistMax = 10'd999;

    // Reciprocal constants for the decimal split
    localparam logic [15:0] RecipHundred = 16'd41;
    localparam logic [14:0] RecipTen = 15'd205;
    localparam logic [9:0] Hundred = 10'd100;
    localparam logic [6:0] Ten = 7'd10;

    // Register indexes on the configuration channel
    localparam logic [CfgIdxWidth-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_TOGGLE_COUNT = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_SCALE = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_TIMEOUT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0] HalfPeriodReset = 8'd12;
    localparam logic [6:0] ToggleCountReset = 7'd16;
    localparam logic [15:0] ScaleReset = 16'd1114;
    localparam logic [15:0] TimeoutReset = 16'd65535;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BURST = 2'd1,
        PH_LISTEN = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] half_period_ticks;
        logic [6:0] toggle_count;
        logic [15:0] scale_q16;
        logic [15:0] timeout_ticks;
    } cfg_t;

    // Result of the ranging core, ahead of the digit split
    typedef struct packed {
        logic tx_level;
        logic busy_res;
        logic done_res;
        logic [DistWidth-1:0] distance_cm;
        logic out_of_range;
    } core_res_t;

endpackage

### src/uer_if.sv
// Tick channel: one beat per microsecond tick
interface uer_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink (input valid, input start_req, input echo, output ready);
endinterface

// Result channel: one beat per tick
interface uer_result_if;
    logic valid;
    logic ready;
    logic tx_level;
    logic busy_res;
    logic done_res;
    logic [uer_pkg::DistWidth-1:0] distance_cm;
    logic out_of_range;
    logic [uer_pkg::DigitWidth-1:0] digit_hundreds;
    logic [uer_pkg::DigitWidth-1:0] digit_tens;
    logic [uer_pkg::DigitWidth-1:0] digit_ones;

    modport source (
        output valid, output tx_level, output busy_res, output done_res,
        output distance_cm, output out_of_range,
        output digit_hundreds, output digit_tens, output digit_ones,
        input ready
    );
    modport sink (
        input valid, input tx_level, input busy_res, input done_res,
        input distance_cm, input out_of_range,
        input digit_hundreds, input digit_tens, input digit_ones,
        output ready
    );
endinterface

// Configuration write channel
interface uer_cfg_if;
    logic valid;
    logic ready;
    logic [uer_pkg::CfgIdxWidth-1:0] index;
    logic [uer_pkg::CfgDataWidth-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/uer_core.sv
module uer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  uer_pkg::cfg_t     cfg,
    input  logic              in_valid,
    input  logic              in_start,
    input  logic              in_echo,
    output logic              in_ready,
    output logic              res_valid,
    input  logic              res_ready,
    output uer_pkg::core_res_t res
);

    localparam logic [uer_pkg::CountWidth-1:0] CountMax = {uer_pkg::CountWidth{1'b1}};

    uer_pkg::phase_t phase_reg, phase_next;
    logic [uer_pkg::CountWidth-1:0] tick_count_reg, tick_count_next;
    logic [6:0] toggles_left_reg, toggles_left_next;
    logic tx_reg, tx_next;
    logic [uer_pkg::DistWidth-1:0] distance_reg, distance_next;
    logic range_flag_reg, range_flag_next;
    logic done_next;

    logic res_valid_reg;
    uer_pkg::core_res_t res_reg;
    logic advance;

    assign in_ready = !res_valid_reg || res_ready;
    assign advance = in_valid && in_ready;

    // Next state for one tick
    always_comb
    begin
        logic [7:0] hp;
        logic [7:0] tc8;
        logic [6:0] tl_dec;
        logic [uer_pkg::CountWidth-1:0] tc_inc;
        logic [uer_pkg::ProdWidth-1:0] prod;
        logic [uer_pkg::CountWidth-1:0] dist_raw;

        phase_next = phase_reg;
        tick_count_next = tick_count_reg;
        toggles_left_next = toggles_left_reg;
        tx_next = tx_reg;
        distance_next = distance_reg;
        range_flag_next = range_flag_reg;
        done_next = 1'b0;

        hp = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
        tc8 = tick_count_reg[7:0] + 8'd1;
        tl_dec = toggles_left_reg - 7'd1;
        tc_inc = (tick_count_reg < CountMax) ? tick_count_reg + 1'b1 : tick_count_reg;
        // Count times scale, Q16
        prod = uer_pkg::ProdWidth'(tick_count_reg) * uer_pkg::ProdWidth'(cfg.scale_q16);
        dist_raw = prod[uer_pkg::ProdWidth-1:16];

        case (phase_reg)
            uer_pkg::PH_BURST:
            begin
                if (toggles_left_reg == 7'd0)
                begin
                    phase_next = uer_pkg::PH_LISTEN;
                    tick_count_next = '0;
                end
                else if (tc8 >= hp)
                begin
                    tx_next = !tx_reg;
                    tick_count_next = '0;
                    toggles_left_next = tl_dec;
                    if (tl_dec == 7'd0)
                    begin
                        phase_next = uer_pkg::PH_LISTEN;
                    end
                end
                else
                begin
                    tick_count_next = uer_pkg::CountWidth'(tc8);
                end
            end
            uer_pkg::PH_LISTEN:
            begin
                if (!in_echo)
                begin
                    // Echo back: scale the count
                    if (uer_pkg::CmpWidth'(dist_raw) > uer_pkg::CmpWidth'(uer_pkg::DistMax))
                    begin
                        distance_next = uer_pkg::DistMax;
                        range_flag_next = 1'b1;
                    end
                    else
                    begin
                        distance_next = uer_pkg::DistWidth'(dist_raw);
                        range_flag_next = 1'b0;
                    end
                    phase_next = uer_pkg::PH_IDLE;
                    tick_count_next = '0;
                    done_next = 1'b1;
                end
                else if (uer_pkg::CmpWidth'(tc_inc) >= uer_pkg::CmpWidth'(cfg.timeout_ticks)
                         || tc_inc == CountMax)
                begin
                    // Timeout or counter full
                    distance_next = uer_pkg::DistMax;
                    range_flag_next = 1'b1;
                    phase_next = uer_pkg::PH_IDLE;
                    tick_count_next = '0;
                    done_next = 1'b1;
                end
                else
                begin
                    tick_count_next = tc_inc;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
                if (in_start)
                begin
                    phase_next = uer_pkg::PH_BURST;
                    tx_next = 1'b0;
                    tick_count_next = '0;
                    toggles_left_next = cfg.toggle_count;
                end
            end
        endcase
    end

    // Ranging state, moves once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            tick_count_reg <= '0;
            toggles_left_reg <= '0;
            tx_reg <= 1'b0;
            distance_reg <= '0;
            range_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_count_reg <= tick_count_next;
            toggles_left_reg <= toggles_left_next;
            tx_reg <= tx_next;
            distance_reg <= distance_next;
            range_flag_reg <= range_flag_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            res_valid_reg <= in_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.tx_level <= tx_next;
            res_reg.busy_res <= (phase_next != uer_pkg::PH_IDLE);
            res_reg.done_res <= done_next;
            res_reg.distance_cm <= distance_next;
            res_reg.out_of_range <= range_flag_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    // A finished measurement leaves the block idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.busy_res)
        else $error("done beat shows busy");

    // Distance never exceeds the display limit
    a_dist_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.distance_cm <= uer_pkg::DistMax)
        else $error("distance above limit");

    // Out-of-range always reports the saturated distance
    a_oor_dist: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.out_of_range |-> res_reg.distance_cm == uer_pkg::DistMax)
        else $error("out of range without saturated distance");

    // State holds while no tick is taken
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(tick_count_reg) && $stable(tx_reg))
        else $error("state moved without a tick");

endmodule

### src/uer_digits.sv
module uer_digits (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  uer_pkg::core_res_t in_res,
    uer_result_if.source       result
);

    logic valid_reg;
    uer_pkg::core_res_t res_reg;
    logic [uer_pkg::DigitWidth-1:0] hund_reg, tens_reg, ones_reg;
    logic [uer_pkg::DigitWidth-1:0] hund_next, tens_next, ones_next;

    assign in_ready = !valid_reg || result.ready;

    // Decimal split by reciprocal multiply, valid for 0..999
    always_comb
    begin
        logic [15:0] h_mul;
        logic [9:0] h_x100;
        logic [9:0] rem10;
        logic [6:0] rem;
        logic [14:0] t_mul;
        logic [6:0] t_x10;
        logic [6:0] o7;

        h_mul = 16'(in_res.distance_cm) * uer_pkg::RecipHundred;
        hund_next = h_mul[15:12];
        h_x100 = 10'(hund_next) * uer_pkg::Hundred;
        rem10 = in_res.distance_cm - h_x100;
        rem = rem10[6:0];
        t_mul = 15'(rem) * uer_pkg::RecipTen;
        tens_next = t_mul[14:11];
        t_x10 = 7'(tens_next) * uer_pkg::Ten;
        o7 = rem - t_x10;
        ones_next = o7[3:0];
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            res_reg <= in_res;
            hund_reg <= hund_next;
            tens_reg <= tens_next;
            ones_reg <= ones_next;
        end
    end

    assign result.valid = valid_reg;
    assign result.tx_level = res_reg.tx_level;
    assign result.busy_res = res_reg.busy_res;
    assign result.done_res = res_reg.done_res;
    assign result.distance_cm = res_reg.distance_cm;
    assign result.out_of_range = res_reg.out_of_range;
    assign result.digit_hundreds = hund_reg;
    assign result.digit_tens = tens_reg;
    assign result.digit_ones = ones_reg;

endmodule

### src/ultrasonic_echo_ranger.sv
// Channel   Role  Beat carries
// tick      sink  start_req, echo (one beat per 1 us tick)
// result    src   tx_level, busy_res, done_res, distance_cm, out_of_range, digits
// cfg       sink  index, data (register write, always ready)
//
// One tick beat in and one result beat out per cycle while result is ready.
// Three register stages: tick register, ranging core, digit split.
// The ranging state updates once per accepted tick; the distance comes
// from one product of the held count and the scale, taken on the echo tick.
// A stall on result backs up through the three stages to tick.ready.
// rst_n clears all control state and loads the register defaults.
module ultrasonic_echo_ranger (
    input  logic          clk,
    input  logic          rst_n,
    uer_tick_if.sink      tick,
    uer_result_if.source  result,
    uer_cfg_if.sink       cfg
);

    uer_pkg::cfg_t cfg_reg;

    logic tick_valid_reg;
    logic start_reg;
    logic echo_reg;
    logic core_ready;

    logic core_valid;
    logic dig_ready;
    uer_pkg::core_res_t core_res;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= uer_pkg::HalfPeriodReset;
            cfg_reg.toggle_count <= uer_pkg::ToggleCountReset;
            cfg_reg.scale_q16 <= uer_pkg::ScaleReset;
            cfg_reg.timeout_ticks <= uer_pkg::TimeoutReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                uer_pkg::CFG_HALF_PERIOD:  cfg_reg.half_period_ticks <= cfg.data[7:0];
                uer_pkg::CFG_TOGGLE_COUNT: cfg_reg.toggle_count <= cfg.data[6:0];
                uer_pkg::CFG_SCALE:        cfg_reg.scale_q16 <= cfg.data;
                uer_pkg::CFG_TIMEOUT:      cfg_reg.timeout_ticks <= cfg.data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Tick input register
    assign tick.ready = !tick_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            tick_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            start_reg <= tick.start_req;
            echo_reg <= tick.echo;
        end
    end

    uer_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (tick_valid_reg),
        .in_start  (start_reg),
        .in_echo   (echo_reg),
        .in_ready  (core_ready),
        .res_valid (core_valid),
        .res_ready (dig_ready),
        .res       (core_res)
    );

    uer_digits u_digits (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (core_valid),
        .in_ready (dig_ready),
        .in_res   (core_res),
        .result   (result)
    );

endmodule
